// File: hdl/xkb_pkg.sv
package xkb_pkg;

   localparam int KEY_BYTES_DEF   = 32;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int KEY_SLOTS       = 32;
   localparam int KEY_IDX_W       = $clog2(KEY_SLOTS);
   localparam int KEY_WORDS       = 4;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_3 = 3'd4;

   localparam logic MODE_ENCRYPT = 1'b0;

   typedef logic [KEY_SLOTS-1:0][7:0] key_type;

   typedef enum logic {
      JOB_CHARS,
      JOB_BYTES
   } job_kind_type;

   // One entry of work for the back end: up to four beats.
   typedef struct packed {
      job_kind_type kind;
      logic [23:0]  data;
      logic [2:0]   data_cnt;
      logic [1:0]   pad_cnt;
      logic         last;
   } job_type;

endpackage

// File: hdl/xor_keystream_base64_codec_core.sv
// Repeating-key XOR with Base64 framing, one message byte per input beat.
// Input channel: req_byte/req_last are taken when req_push is high and req_full
// low. Result channel: the oldest result sits on rsp_byte/rsp_valid/rsp_last
// while rsp_empty is low and is taken when rsp_pop is high.
// Configuration: csr_we writes csr_wdata to register csr_index (0 mode, 1 to 4
// key words) at once; write only while no message is in flight.
// The front end takes one beat every cycle unless req_full is high, updates the
// group and key position and queues at most one job of up to four result beats.
// The back end plays a job out at one result per cycle while rsp_pop is high, so
// encoding sustains three input beats per four results, decoding one per cycle.
// A result is registered in the job queue and then in the back end's job register
// before it reaches the result ports, where it can be popped.
// When the receiver stalls, the current result holds, the job queue fills and
// req_full rises once it is full; nothing is dropped.
// Reset clears the mode, key, group state and queue; no clearing pass is needed.
module xor_keystream_base64_codec_core #(
   parameter int KEY_BYTES   = xkb_pkg::KEY_BYTES_DEF,
   parameter int QUEUE_DEPTH = xkb_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [7:0]                      req_byte,
   input  logic                            req_last,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [7:0]                      rsp_byte,
   output logic                            rsp_valid,
   output logic                            rsp_last,
   input  logic                            csr_we,
   input  logic [xkb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [xkb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import xkb_pkg::*;

   logic                                 mode_ff;
   logic [KEY_WORDS-1:0][CSR_DATA_W-1:0] key_ff;
   key_type                              key_bytes;

   logic    accept;
   logic    job_valid;
   job_type job;
   job_type head;
   logic    head_empty;
   logic    head_pop;

   assign key_bytes = key_ff;
   assign accept    = req_push && !req_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENCRYPT;
         key_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:  mode_ff   <= csr_wdata[0];
            CSR_KEY_0: key_ff[0] <= csr_wdata;
            CSR_KEY_1: key_ff[1] <= csr_wdata;
            CSR_KEY_2: key_ff[2] <= csr_wdata;
            CSR_KEY_3: key_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   xkb_front #(
      .KEY_BYTES (KEY_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept_i    (accept),
      .byte_i      (req_byte),
      .last_i      (req_last),
      .mode_i      (mode_ff),
      .key_i       (key_bytes),
      .job_valid_o (job_valid),
      .job_o       (job)
   );

   xkb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_i      (accept && job_valid),
      .push_data_i (job),
      .full_o      (req_full),
      .pop_i       (head_pop),
      .head_o      (head),
      .empty_o     (head_empty)
   );

   xkb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_i       (head),
      .head_empty_i (head_empty),
      .head_pop_o   (head_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_byte     (rsp_byte),
      .rsp_valid    (rsp_valid),
      .rsp_last     (rsp_last)
   );

endmodule

// File: hdl/xkb_front.sv
module xkb_front #(
   parameter int KEY_BYTES = xkb_pkg::KEY_BYTES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept_i,
   input  logic [7:0]      byte_i,
   input  logic            last_i,
   input  logic            mode_i,
   input  xkb_pkg::key_type key_i,
   output logic            job_valid_o,
   output xkb_pkg::job_type job_o
);
   import xkb_pkg::*;

   localparam int POS_W = $clog2(KEY_BYTES);

   logic [23:0]      group_ff, group_in;
   logic [1:0]       fill_ff, fill_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             stopped_ff, stopped_in;

   logic [POS_W-1:0] p1, p2, p3;
   logic [7:0]       k0, k1, k2;
   logic [7:0]       kb;
   logic [23:0]      enc_g;
   logic [2:0]       enc_fill;
   logic [6:0]       sx;

   function automatic logic [POS_W-1:0] pos_next(input logic [POS_W-1:0] p);
      if (p == POS_W'(KEY_BYTES - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   // Bit 6 flags a character outside the alphabet.
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return 7'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         return 7'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         return 7'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         return 7'd62;
      end else if (c == 8'h2F) begin
         return 7'd63;
      end
      return 7'd64;
   endfunction

   assign p1 = pos_next(pos_ff);
   assign p2 = pos_next(p1);
   assign p3 = pos_next(p2);
   assign k0 = key_i[KEY_IDX_W'(pos_ff)];
   assign k1 = key_i[KEY_IDX_W'(p1)];
   assign k2 = key_i[KEY_IDX_W'(p2)];
   assign kb = byte_i ^ k0;
   assign enc_g = {group_ff[15:0], kb};
   assign enc_fill = {1'b0, fill_ff} + 3'd1;
   assign sx = sextet_of(byte_i);

   always_comb begin
      group_in    = group_ff;
      fill_in     = fill_ff;
      pos_in      = pos_ff;
      stopped_in  = stopped_ff;
      job_valid_o = 1'b0;
      job_o       = '0;
      if (mode_i == MODE_ENCRYPT) begin
         job_o.kind = JOB_CHARS;
         pos_in     = p1;
         if (enc_fill >= 3'd3) begin
            job_valid_o    = 1'b1;
            job_o.data     = enc_g;
            job_o.data_cnt = 3'd4;
            group_in       = '0;
            fill_in        = '0;
         end else begin
            group_in = enc_g;
            fill_in  = enc_fill[1:0];
         end
         if (last_i && fill_in != 2'd0) begin
            job_valid_o    = 1'b1;
            job_o.data     = (fill_in == 2'd1) ? {group_in[7:0], 16'h0}
                                               : {group_in[15:0], 8'h0};
            job_o.data_cnt = {1'b0, fill_in} + 3'd1;
            job_o.pad_cnt  = 2'd3 - fill_in;
         end
      end else begin
         job_o.kind = JOB_BYTES;
         if (!stopped_ff) begin
            if (sx[6]) begin
               stopped_in = 1'b1;
            end else if (fill_ff == 2'd3) begin
               job_valid_o    = 1'b1;
               job_o.data     = {group_ff[17:0], sx[5:0]} ^ {k0, k1, k2};
               job_o.data_cnt = 3'd3;
               group_in       = '0;
               fill_in        = '0;
               pos_in         = p3;
            end else begin
               group_in = {group_ff[17:0], sx[5:0]};
               fill_in  = fill_ff + 2'd1;
            end
         end
         // A tail of one sextet carries no whole byte.
         if (last_i && fill_in != 2'd0) begin
            job_o.data     = ((fill_in == 2'd3) ? {group_in[17:0], 6'h0}
                                                : {group_in[11:0], 12'h0})
                             ^ {k0, k1, k2};
            job_o.data_cnt = {1'b0, fill_in} - 3'd1;
         end
      end
      if (last_i) begin
         job_valid_o = 1'b1;
         job_o.last  = 1'b1;
         group_in    = '0;
         fill_in     = '0;
         pos_in      = '0;
         stopped_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff   <= '0;
         fill_ff    <= '0;
         pos_ff     <= '0;
         stopped_ff <= 1'b0;
      end else if (accept_i) begin
         group_ff   <= group_in;
         fill_ff    <= fill_in;
         pos_ff     <= pos_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// File: hdl/xkb_queue.sv
module xkb_queue #(
   parameter int DEPTH = xkb_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_i,
   input  xkb_pkg::job_type push_data_i,
   output logic             full_o,
   input  logic             pop_i,
   output xkb_pkg::job_type head_o,
   output logic             empty_o
);
   import xkb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign full_o  = (count_ff == CNT_W'(DEPTH));
   assign empty_o = (count_ff == '0);
   assign head_o  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_i ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_i ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_i && !pop_i) begin
         count_in = count_ff + 1'b1;
      end else if (pop_i && !push_i) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ptr_ff] <= push_data_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hdl/xkb_back.sv
module xkb_back (
   input  logic             clock,
   input  logic             reset,
   input  xkb_pkg::job_type head_i,
   input  logic             head_empty_i,
   output logic             head_pop_o,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_byte,
   output logic             rsp_valid,
   output logic             rsp_last
);
   import xkb_pkg::*;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   job_type    job_ff, job_in;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;

   logic [2:0] total;
   logic       final_beat;
   logic       beat_done;
   logic       load;
   logic [5:0] sextet;
   logic [7:0] data_byte;

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      if (v < 6'd26) begin
         return 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         return 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         return 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         return 8'h2B;
      end
      return 8'h2F;
   endfunction

   assign total      = job_ff.data_cnt + {1'b0, job_ff.pad_cnt};
   assign final_beat = (total == 3'd0) || ({1'b0, idx_ff} == total - 3'd1);
   assign beat_done  = busy_ff && rsp_pop;
   assign load       = !busy_ff || (beat_done && final_beat);
   assign head_pop_o = load && !head_empty_i;

   always_comb begin
      case (idx_ff)
         2'd0: begin
            sextet    = job_ff.data[23:18];
            data_byte = job_ff.data[23:16];
         end
         2'd1: begin
            sextet    = job_ff.data[17:12];
            data_byte = job_ff.data[15:8];
         end
         2'd2: begin
            sextet    = job_ff.data[11:6];
            data_byte = job_ff.data[7:0];
         end
         default: begin
            sextet    = job_ff.data[5:0];
            data_byte = job_ff.data[7:0];
         end
      endcase
   end

   always_comb begin
      rsp_empty = !busy_ff;
      rsp_last  = job_ff.last && final_beat;
      rsp_valid = 1'b1;
      if (total == 3'd0) begin
         rsp_byte  = 8'h00;
         rsp_valid = 1'b0;
      end else if ({1'b0, idx_ff} >= job_ff.data_cnt) begin
         rsp_byte = PAD_CHAR;
      end else if (job_ff.kind == JOB_CHARS) begin
         rsp_byte = b64_char(sextet);
      end else begin
         rsp_byte = data_byte;
      end
   end

   always_comb begin
      job_in  = job_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         job_in  = head_i;
         busy_in = !head_empty_i;
         idx_in  = '0;
      end else if (beat_done) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

endmodule
